/* hdl/software_timer_table_defines.svh */
// assertion macros shared by the timer table rtl
// used by software_timer_table.sv; no other dependencies
`ifndef SOFTWARE_TIMER_TABLE_DEFINES_SVH
`define SOFTWARE_TIMER_TABLE_DEFINES_SVH

// same-cycle implication
`define STT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define STT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/stt_pkg.sv */
// package for the timer table: sizes, request and status codes, entry types
// no dependencies
`default_nettype none

package stt_pkg;

    localparam int MAX_TIMERS = 16;
    localparam int ID_W       = 16;
    localparam int TICK_W     = 16;
    localparam int REQ_W      = 2;
    localparam int STAT_W     = 2;
    localparam int CNT_W      = $clog2(MAX_TIMERS + 1);
    localparam int IDX_W      = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;

    localparam logic [REQ_W-1:0] REQ_SET  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_KILL = 2'd1;
    localparam logic [REQ_W-1:0] REQ_TICK = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [ID_W-1:0]   ident;
        logic [TICK_W-1:0] remaining;
    } entry_t;

    typedef struct packed {
        logic              keep;
        logic              expire;
        logic              match;
        logic [TICK_W-1:0] remaining;
    } eval_t;

endpackage

`default_nettype wire

/* hdl/stt_req_if.sv */
// request channel of the timer table: valid/ready plus request payload
// depends on stt_pkg
`default_nettype none

interface stt_req_if;

    logic                         valid;
    logic                         ready;
    logic [stt_pkg::REQ_W-1:0]    req_type;
    logic [stt_pkg::ID_W-1:0]     timer_id;
    logic [stt_pkg::TICK_W-1:0]   ticks;

    modport source (output valid, output req_type, output timer_id, output ticks,
                    input ready);
    modport sink   (input valid, input req_type, input timer_id, input ticks,
                    output ready);

endinterface

`default_nettype wire

/* hdl/stt_rsp_if.sv */
// result channel of the timer table: valid/ready plus result payload
// depends on stt_pkg
`default_nettype none

interface stt_rsp_if;

    logic                         valid;
    logic                         ready;
    logic [stt_pkg::STAT_W-1:0]   status;
    logic                         fired;
    logic [stt_pkg::ID_W-1:0]     expired_id;
    logic                         last;

    modport source (output valid, output status, output fired, output expired_id,
                    output last, input ready);
    modport sink   (input valid, input status, input fired, input expired_id,
                    input last, output ready);

endinterface

`default_nettype wire

/* hdl/stt_entry_unit.sv */
// shared per-entry unit: id compare, expiry check and new countdown value
// depends on stt_pkg
`default_nettype none

module stt_entry_unit (
    input  wire logic [stt_pkg::REQ_W-1:0]  req_type,
    input  wire logic [stt_pkg::ID_W-1:0]   timer_id,
    input  wire logic [stt_pkg::TICK_W-1:0] ticks,
    input  wire stt_pkg::entry_t            entry,
    output stt_pkg::eval_t                  result
);

    logic is_set;
    logic is_kill;
    logic is_tick;
    logic match;
    logic expire;

    assign is_set  = (req_type == stt_pkg::REQ_SET);
    assign is_kill = (req_type == stt_pkg::REQ_KILL);
    assign is_tick = (req_type == stt_pkg::REQ_TICK);
    assign match   = (entry.ident == timer_id);
    // at most one tick left
    assign expire  = is_tick && (entry.remaining[stt_pkg::TICK_W-1:1] == '0);

    always_comb
    begin
        result.match  = match;
        result.expire = expire;
        result.keep   = !expire && !(is_kill && match);
        if (is_tick)
        begin
            result.remaining = entry.remaining - stt_pkg::TICK_W'(1);
        end
        else if (is_set && match)
        begin
            result.remaining = ticks;
        end
        else
        begin
            result.remaining = entry.remaining;
        end
    end

endmodule

`default_nettype wire

/* hdl/software_timer_table.sv */
// Timer table of up to MAX_TIMERS one-shot countdown timers kept in insertion order.
// A set request re-arms a matching id or appends a new entry (status full when no slot
// is left); a kill removes the matching id (status 1 when absent), and kill with id 0
// empties the table. A tick emits one item per expired timer in list order with last on
// the final one, or a single empty item when nothing expired. One request is handled at
// a time: the table sits in a memory with one read and one write port that is walked
// one entry per cycle, unless back-pressure on the result channel stalls it, through one
// shared compare/decrement unit; kill-all and unused codes skip the walk.
// Table contents are not cleared by reset; only the active count is.
// depends on stt_pkg, stt_req_if, stt_rsp_if, stt_entry_unit and the defines header
`default_nettype none
`include "software_timer_table_defines.svh"

module software_timer_table (
    input  wire logic clk,
    input  wire logic rst_n,
    stt_req_if.sink   req,
    stt_rsp_if.source rsp
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DONE
    } state_t;

    state_t                          state_reg, state_next;
    logic [stt_pkg::CNT_W-1:0]       count_reg, count_next;
    logic [stt_pkg::CNT_W-1:0]       rd_idx_reg, rd_idx_next;
    logic [stt_pkg::CNT_W-1:0]       wr_idx_reg, wr_idx_next;
    logic                            eval_valid_reg, eval_valid_next;
    logic                            found_reg, found_next;
    logic                            hold_valid_reg, hold_valid_next;
    logic [stt_pkg::ID_W-1:0]        hold_id_reg, hold_id_next;
    logic [stt_pkg::REQ_W-1:0]       req_type_reg, req_type_next;
    logic [stt_pkg::ID_W-1:0]        timer_id_reg, timer_id_next;
    logic [stt_pkg::TICK_W-1:0]      ticks_reg, ticks_next;
    logic                            out_valid_reg, out_valid_next;
    logic [stt_pkg::STAT_W-1:0]      out_status_reg, out_status_next;
    logic                            out_fired_reg, out_fired_next;
    logic [stt_pkg::ID_W-1:0]        out_id_reg, out_id_next;
    logic                            out_last_reg, out_last_next;

    stt_pkg::entry_t                 mem [stt_pkg::MAX_TIMERS];
    stt_pkg::entry_t                 rd_data_reg;
    stt_pkg::entry_t                 wr_data;
    stt_pkg::eval_t                  ev;
    logic [stt_pkg::IDX_W-1:0]       wr_addr;
    logic                            wr_en;
    logic                            rd_en;
    logic                            out_free;
    logic                            stall;
    logic                            accept;

    assign accept   = req.valid && req.ready;
    assign out_free = !out_valid_reg || rsp.ready;
    assign stall    = eval_valid_reg && ev.expire && hold_valid_reg && !out_free;

    assign req.ready      = (state_reg == S_IDLE);
    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.fired      = out_fired_reg;
    assign rsp.expired_id = out_id_reg;
    assign rsp.last       = out_last_reg;

    stt_entry_unit u_entry (
        .req_type (req_type_reg),
        .timer_id (timer_id_reg),
        .ticks    (ticks_reg),
        .entry    (rd_data_reg),
        .result   (ev)
    );

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_idx_reg[stt_pkg::IDX_W-1:0]];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        rd_idx_next     = rd_idx_reg;
        wr_idx_next     = wr_idx_reg;
        eval_valid_next = eval_valid_reg;
        found_next      = found_reg;
        hold_valid_next = hold_valid_reg;
        hold_id_next    = hold_id_reg;
        req_type_next   = req_type_reg;
        timer_id_next   = timer_id_reg;
        ticks_next      = ticks_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_fired_next  = out_fired_reg;
        out_id_next     = out_id_reg;
        out_last_next   = out_last_reg;
        wr_en           = 1'b0;
        wr_addr         = wr_idx_reg[stt_pkg::IDX_W-1:0];
        wr_data         = '{ident: rd_data_reg.ident, remaining: ev.remaining};
        rd_en           = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    req_type_next   = req.req_type;
                    timer_id_next   = req.timer_id;
                    ticks_next      = req.ticks;
                    rd_idx_next     = '0;
                    wr_idx_next     = '0;
                    eval_valid_next = 1'b0;
                    found_next      = 1'b0;
                    hold_valid_next = 1'b0;
                    if ((req.req_type == stt_pkg::REQ_KILL && req.timer_id == '0) ||
                        (req.req_type != stt_pkg::REQ_SET &&
                         req.req_type != stt_pkg::REQ_KILL &&
                         req.req_type != stt_pkg::REQ_TICK))
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_WALK;
                    end
                end
            end
            S_WALK:
            begin
                if (!stall)
                begin
                    if (eval_valid_reg)
                    begin
                        if (ev.match)
                        begin
                            found_next = 1'b1;
                        end
                        if (ev.keep)
                        begin
                            wr_en       = 1'b1;
                            wr_idx_next = wr_idx_reg + 1'b1;
                        end
                        if (ev.expire)
                        begin
                            hold_valid_next = 1'b1;
                            hold_id_next    = rd_data_reg.ident;
                            if (hold_valid_reg)
                            begin
                                out_valid_next  = 1'b1;
                                out_status_next = stt_pkg::ST_OK;
                                out_fired_next  = 1'b1;
                                out_id_next     = hold_id_reg;
                                out_last_next   = 1'b0;
                            end
                        end
                    end
                    if (rd_idx_reg < count_reg)
                    begin
                        rd_en           = 1'b1;
                        rd_idx_next     = rd_idx_reg + 1'b1;
                        eval_valid_next = 1'b1;
                    end
                    else
                    begin
                        eval_valid_next = 1'b0;
                        state_next      = S_DONE;
                    end
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next      = S_IDLE;
                    out_valid_next  = 1'b1;
                    out_status_next = stt_pkg::ST_OK;
                    out_fired_next  = 1'b0;
                    out_id_next     = '0;
                    out_last_next   = 1'b1;
                    if (req_type_reg == stt_pkg::REQ_SET)
                    begin
                        if (!found_reg)
                        begin
                            if (count_reg == stt_pkg::CNT_W'(stt_pkg::MAX_TIMERS))
                            begin
                                out_status_next = stt_pkg::ST_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_data    = '{ident: timer_id_reg, remaining: ticks_reg};
                                count_next = count_reg + 1'b1;
                            end
                        end
                    end
                    else if (req_type_reg == stt_pkg::REQ_KILL)
                    begin
                        count_next = wr_idx_reg;
                        if (!found_reg)
                        begin
                            out_status_next = stt_pkg::ST_MISS;
                        end
                    end
                    else if (req_type_reg == stt_pkg::REQ_TICK)
                    begin
                        count_next = wr_idx_reg;
                        if (hold_valid_reg)
                        begin
                            out_fired_next = 1'b1;
                            out_id_next    = hold_id_reg;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            rd_idx_reg     <= '0;
            wr_idx_reg     <= '0;
            eval_valid_reg <= 1'b0;
            found_reg      <= 1'b0;
            hold_valid_reg <= 1'b0;
            hold_id_reg    <= '0;
            req_type_reg   <= stt_pkg::REQ_SET;
            timer_id_reg   <= '0;
            ticks_reg      <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= stt_pkg::ST_OK;
            out_fired_reg  <= 1'b0;
            out_id_reg     <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            rd_idx_reg     <= rd_idx_next;
            wr_idx_reg     <= wr_idx_next;
            eval_valid_reg <= eval_valid_next;
            found_reg      <= found_next;
            hold_valid_reg <= hold_valid_next;
            hold_id_reg    <= hold_id_next;
            req_type_reg   <= req_type_next;
            timer_id_reg   <= timer_id_next;
            ticks_reg      <= ticks_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_fired_reg  <= out_fired_next;
            out_id_reg     <= out_id_next;
            out_last_reg   <= out_last_next;
        end
    end

    // compaction never writes ahead of the read pointer
    `STT_ASSERT_IMP(a_wr_behind_rd, clk, rst_n, state_reg == S_WALK,
        wr_idx_reg <= rd_idx_reg, "write index passed read index")
    // table grows by at most one entry per item
    `STT_ASSERT_NXT(a_count_step, clk, rst_n, 1'b1,
        count_reg <= $past(count_reg) + 1'b1, "active count grew by more than one")
    // an empty result always closes its request
    `STT_ASSERT_IMP(a_empty_is_last, clk, rst_n, rsp.valid && !rsp.fired,
        rsp.last, "non-fired item without last")
    // a held expiry only exists while ticking
    `STT_ASSERT_IMP(a_hold_tick, clk, rst_n, hold_valid_reg && state_reg != S_IDLE,
        req_type_reg == stt_pkg::REQ_TICK, "held expiry outside a tick")

endmodule

`default_nettype wire

/* sim/tb_software_timer_table.sv */
`timescale 1ns / 1ps
// self-checking testbench for software_timer_table: directed and random set/kill/tick requests
// results are predicted in the bench and checked item by item against the result channel
// depends on stt_pkg, stt_req_if, stt_rsp_if and the software_timer_table rtl
module tb_software_timer_table;

    localparam logic [stt_pkg::REQ_W-1:0] REQ_NOP = 2'd3;
    localparam int ID_POOL_SIZE = 20;
    localparam int RANDOM_ITEMS = 255;

    typedef struct packed {
        logic [stt_pkg::REQ_W-1:0]  kind;
        logic [stt_pkg::ID_W-1:0]   ident;
        logic [stt_pkg::TICK_W-1:0] len;
    } timer_req_t;

    typedef struct packed {
        logic [stt_pkg::STAT_W-1:0] status;
        logic                       fired;
        logic [stt_pkg::ID_W-1:0]   expired_id;
        logic                       last;
    } timer_rsp_t;

    logic clk;
    logic rst_n = 1'b0;

    stt_req_if req_ch ();
    stt_rsp_if rsp_ch ();

    software_timer_table dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    logic       drv_valid  = 1'b0;
    timer_req_t drv_item   = '0;
    logic       sink_ready = 1'b0;

    assign req_ch.valid    = drv_valid;
    assign req_ch.req_type = drv_item.kind;
    assign req_ch.timer_id = drv_item.ident;
    assign req_ch.ticks    = drv_item.len;
    assign rsp_ch.ready    = sink_ready;

    // shadow copy of the timer list
    logic [stt_pkg::ID_W-1:0]   tbl_ident [stt_pkg::MAX_TIMERS];
    logic [stt_pkg::TICK_W-1:0] tbl_left  [stt_pkg::MAX_TIMERS];
    int                         tbl_count = 0;

    timer_req_t pending_reqs [$];
    timer_rsp_t due_results  [$];
    logic [stt_pkg::ID_W-1:0] id_pool [ID_POOL_SIZE];

    bit req_hs = 1'b0;
    bit rsp_hs = 1'b0;
    int send_gap = 0, send_calm = 0;
    int recv_gap = 0, recv_calm = 0, hold_left = 0;
    bit hold_done = 1'b0;

    int fail_count   = 0;
    int results_seen = 0;
    int reqs_seen    = 0;
    int sets_seen    = 0;
    int kills_seen   = 0;
    int ticks_seen   = 0;
    int fired_total  = 0;
    int full_seen    = 0;
    int max_burst    = 0;

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    initial begin
        #3_000_000;
        $display("** software_timer_table: FAILED **");
        $finish;
    end

    function automatic int pick_gap(inout int calm);
        int roll;
        roll = $urandom_range(0, 99);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
            calm = $urandom_range(15, 40);
        if (roll < 55)
            return 0;
        else if (roll < 85)
            return $urandom_range(1, 3);
        else if (roll < 95)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic logic [stt_pkg::ID_W-1:0] pick_id();
        if ($urandom_range(0, 9) < 7)
            return id_pool[$urandom_range(0, ID_POOL_SIZE - 1)];
        return stt_pkg::ID_W'($urandom_range(0, 65535));
    endfunction

    function automatic logic [stt_pkg::TICK_W-1:0] pick_len();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 6)
            return stt_pkg::TICK_W'($urandom_range(0, 6));
        else if (roll < 8)
            return stt_pkg::TICK_W'($urandom_range(7, 40));
        return stt_pkg::TICK_W'($urandom_range(0, 65535));
    endfunction

    task automatic queue_req(input logic [stt_pkg::REQ_W-1:0] kind,
                             input logic [stt_pkg::ID_W-1:0] ident,
                             input logic [stt_pkg::TICK_W-1:0] len);
        timer_req_t item;
        item.kind  = kind;
        item.ident = ident;
        item.len   = len;
        pending_reqs.push_back(item);
    endtask

    task automatic push_result(input logic [stt_pkg::STAT_W-1:0] status, input logic fired,
                               input logic [stt_pkg::ID_W-1:0] ident, input logic last);
        timer_rsp_t res;
        res.status     = status;
        res.fired      = fired;
        res.expired_id = ident;
        res.last       = last;
        due_results.push_back(res);
    endtask

    // updates the shadow list and queues the items this request must produce
    task automatic apply_request(input timer_req_t r);
        int hit;
        int kept;
        int n_fired;
        timer_rsp_t res;
        hit = -1;
        reqs_seen++;
        for (int i = 0; i < tbl_count; i++)
            if (hit < 0 && tbl_ident[i] == r.ident)
                hit = i;
        case (r.kind)
            stt_pkg::REQ_SET:
            begin
                sets_seen++;
                if (hit >= 0) begin
                    tbl_left[hit] = r.len;
                    push_result(stt_pkg::ST_OK, 1'b0, '0, 1'b1);
                end else if (tbl_count >= stt_pkg::MAX_TIMERS) begin
                    full_seen++;
                    push_result(stt_pkg::ST_FULL, 1'b0, '0, 1'b1);
                end else begin
                    tbl_ident[tbl_count] = r.ident;
                    tbl_left[tbl_count]  = r.len;
                    tbl_count++;
                    push_result(stt_pkg::ST_OK, 1'b0, '0, 1'b1);
                end
            end
            stt_pkg::REQ_KILL:
            begin
                kills_seen++;
                if (r.ident == '0) begin
                    tbl_count = 0;
                    push_result(stt_pkg::ST_MISS, 1'b0, '0, 1'b1);
                end else if (hit >= 0) begin
                    for (int j = hit; j + 1 < tbl_count; j++) begin
                        tbl_ident[j] = tbl_ident[j + 1];
                        tbl_left[j]  = tbl_left[j + 1];
                    end
                    tbl_count--;
                    push_result(stt_pkg::ST_OK, 1'b0, '0, 1'b1);
                end else begin
                    push_result(stt_pkg::ST_MISS, 1'b0, '0, 1'b1);
                end
            end
            stt_pkg::REQ_TICK:
            begin
                ticks_seen++;
                kept    = 0;
                n_fired = 0;
                for (int i = 0; i < tbl_count; i++) begin
                    if (tbl_left[i] <= 1) begin
                        push_result(stt_pkg::ST_OK, 1'b1, tbl_ident[i], 1'b0);
                        n_fired++;
                    end else begin
                        tbl_ident[kept] = tbl_ident[i];
                        tbl_left[kept]  = tbl_left[i] - 1'b1;
                        kept++;
                    end
                end
                tbl_count = kept;
                if (n_fired == 0) begin
                    push_result(stt_pkg::ST_OK, 1'b0, '0, 1'b1);
                end else begin
                    res = due_results.pop_back();
                    res.last = 1'b1;
                    due_results.push_back(res);
                end
                fired_total += n_fired;
                if (n_fired > max_burst)
                    max_burst = n_fired;
            end
            default:
            begin
                push_result(stt_pkg::ST_OK, 1'b0, '0, 1'b1);
            end
        endcase
    endtask

    task automatic note_failure(input string what, input timer_rsp_t want,
                                input timer_rsp_t got);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t %s: expected status=%0d fired=%0d id=%h last=%0d, %s",
                     $time, what, want.status, want.fired, want.expired_id, want.last,
                     $sformatf("got status=%0d fired=%0d id=%h last=%0d",
                               got.status, got.fired, got.expired_id, got.last));
    endtask

    // request driver
    always @(negedge clk) begin
        if (rst_n && !(drv_valid && !req_hs)) begin
            if (drv_valid)
                send_gap = pick_gap(send_calm);
            if (send_gap > 0) begin
                send_gap--;
                drv_valid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
                drv_item  <= pending_reqs.pop_front();
                drv_valid <= 1'b1;
            end else begin
                drv_valid <= 1'b0;
            end
        end
    end

    // result receiver, with one long hold-off to back up the table
    always @(negedge clk) begin
        if (rst_n) begin
            if (rsp_hs)
                recv_gap = pick_gap(recv_calm);
            if (!hold_done && results_seen >= 80) begin
                hold_done = 1'b1;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                sink_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                sink_ready <= 1'b0;
            end else begin
                sink_ready <= 1'b1;
            end
        end
    end

    // monitor and checker
    always @(posedge clk) begin
        timer_req_t seen_req;
        timer_rsp_t got;
        timer_rsp_t want;
        req_hs = rst_n && req_ch.valid && req_ch.ready;
        rsp_hs = rst_n && rsp_ch.valid && rsp_ch.ready;
        if (rsp_hs) begin
            results_seen++;
            got.status     = rsp_ch.status;
            got.fired      = rsp_ch.fired;
            got.expired_id = rsp_ch.expired_id;
            got.last       = rsp_ch.last;
            if (due_results.size() == 0) begin
                note_failure("unexpected item", '0, got);
            end else begin
                want = due_results.pop_front();
                if (got.status !== want.status || got.fired !== want.fired ||
                    got.expired_id !== want.expired_id || got.last !== want.last)
                    note_failure("mismatch", want, got);
            end
        end
        if (req_hs) begin
            seen_req.kind  = req_ch.req_type;
            seen_req.ident = req_ch.timer_id;
            seen_req.len   = req_ch.ticks;
            apply_request(seen_req);
        end
    end

    initial begin
        int roll;
        for (int k = 0; k < ID_POOL_SIZE; k++)
            id_pool[k] = stt_pkg::ID_W'($urandom_range(1, 65535));

        // directed: empty table, field extremes, full table, biggest tick burst, kills
        queue_req(stt_pkg::REQ_TICK, '0, '0);
        queue_req(stt_pkg::REQ_KILL, 16'h1234, '0);
        queue_req(REQ_NOP, 16'hFFFF, 16'hFFFF);
        queue_req(stt_pkg::REQ_SET, 16'h0000, 16'h0000);
        queue_req(stt_pkg::REQ_SET, 16'hFFFF, 16'hFFFF);
        for (int k = 0; k < stt_pkg::MAX_TIMERS - 2; k++)
            queue_req(stt_pkg::REQ_SET, stt_pkg::ID_W'(1 << k), 16'd1);
        queue_req(stt_pkg::REQ_SET, 16'hABCD, 16'd5);
        queue_req(stt_pkg::REQ_SET, 16'hFFFF, 16'd1);
        queue_req(stt_pkg::REQ_TICK, '0, '0);
        queue_req(stt_pkg::REQ_SET, 16'h0055, 16'd3);
        queue_req(stt_pkg::REQ_SET, 16'h00AA, 16'd2);
        queue_req(stt_pkg::REQ_SET, 16'h0101, 16'd9);
        queue_req(stt_pkg::REQ_KILL, 16'h00AA, '0);
        queue_req(stt_pkg::REQ_KILL, 16'h0000, 16'hFFFF);
        queue_req(stt_pkg::REQ_TICK, '0, '0);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 42)
                queue_req(stt_pkg::REQ_SET, pick_id(), pick_len());
            else if (roll < 59)
                queue_req(stt_pkg::REQ_KILL, pick_id(),
                          stt_pkg::TICK_W'($urandom_range(0, 65535)));
            else if (roll < 61)
                queue_req(stt_pkg::REQ_KILL, '0, stt_pkg::TICK_W'($urandom_range(0, 65535)));
            else if (roll < 97)
                queue_req(stt_pkg::REQ_TICK, stt_pkg::ID_W'($urandom_range(0, 65535)),
                          stt_pkg::TICK_W'($urandom_range(0, 65535)));
            else
                queue_req(REQ_NOP, stt_pkg::ID_W'($urandom_range(0, 65535)),
                          stt_pkg::TICK_W'($urandom_range(0, 65535)));
        end

        @(posedge rst_n);
        while (pending_reqs.size() != 0 || drv_valid)
            @(posedge clk);
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("run covered %0d requests: %0d sets (%0d rejected as full), %0d kills, %0d ticks",
                 reqs_seen, sets_seen, full_seen, kills_seen, ticks_seen);
        $display("%0d result items checked, %0d timers fired, up to %0d in one tick",
                 results_seen, fired_total, max_burst);
        if (fail_count == 0)
            $display("** software_timer_table: PASSED **");
        else
            $display("** software_timer_table: FAILED **");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hdl
hdl/stt_pkg.sv
hdl/stt_req_if.sv
hdl/stt_rsp_if.sv
hdl/stt_entry_unit.sv
hdl/software_timer_table.sv
sim/tb_software_timer_table.sv
